>>> rtl/athm_pkg.sv
package athm_pkg;

  localparam int AVG_LOG2 = 8;
  localparam int SMP_W    = 12;
  localparam int SUM_W    = SMP_W + AVG_LOG2;
  localparam int GAIN_W   = 16;
  localparam int SHIFT_W  = 5;
  localparam int RES_W    = 16;
  localparam int PPROD_W  = SMP_W + GAIN_W;
  localparam int TPROD_W  = (SMP_W + 1) + (GAIN_W + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_POT_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_SHIFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_ZERO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SHIFT = 3'd5;

  localparam logic [GAIN_W-1:0]         RST_POT_GAIN   = 16'd31;
  localparam logic [SHIFT_W-1:0]        RST_POT_SHIFT  = 5'd12;
  localparam logic signed [RES_W-1:0]   RST_POT_OFFSET = 16'sd55;
  localparam logic [SMP_W-1:0]          RST_TEMP_ZERO  = 12'd2475;
  localparam logic [GAIN_W-1:0]         RST_TEMP_GAIN  = 16'd12084;
  localparam logic [SHIFT_W-1:0]        RST_TEMP_SHIFT = 5'd16;

  typedef struct packed {
    logic [GAIN_W-1:0]       pot_gain;
    logic [SHIFT_W-1:0]      pot_shift;
    logic signed [RES_W-1:0] pot_offset;
    logic [SMP_W-1:0]        temp_zero;
    logic [GAIN_W-1:0]       temp_gain;
    logic [SHIFT_W-1:0]      temp_shift;
  } cfg_t;

  typedef struct packed {
    logic                      next_ch;
    logic                      done;
    logic [PPROD_W-1:0]        pprod;
    logic signed [TPROD_W-1:0] tprod;
  } prod_t;

  typedef struct packed {
    logic                    next_ch;
    logic                    done;
    logic signed [RES_W-1:0] setpoint;
    logic signed [RES_W-1:0] actual_temp;
    logic                    drive_on;
  } res_t;

  function automatic logic signed [RES_W-1:0] sat16(input logic signed [TPROD_W-1:0] v);
    logic signed [TPROD_W-1:0] hi;
    logic signed [TPROD_W-1:0] lo;
    hi = TPROD_W'(32767);
    lo = -TPROD_W'(32768);
    if (v > hi) begin
      sat16 = 16'sh7fff;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[RES_W-1:0];
    end
  endfunction

endpackage

>>> rtl/athm_if.sv
interface athm_in_if;
  import athm_pkg::*;
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface athm_out_if;
  import athm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    next_channel;
  logic                    batch_done;
  logic signed [RES_W-1:0] setpoint;
  logic signed [RES_W-1:0] actual_temp;
  logic                    drive_on;
  modport source (output valid, output next_channel, output batch_done, output setpoint,
                  output actual_temp, output drive_on, input ready);
  modport sink (input valid, input next_channel, input batch_done, input setpoint,
                input actual_temp, input drive_on, output ready);
endinterface

>>> rtl/averaged_adc_thermostat.sv
// Averaged converter thermostat. Feed samples alternately, potentiometer first, then
// temperature; each one returns a word naming the channel to sample next. After 256
// pairs the averaged readings are scaled, saturated to 16 bits signed and compared;
// batch_done marks that word, and setpoint, actual_temp and drive_on hold until the
// next batch. One sample per clock is accepted; each result passes through an input
// register, a multiply stage and a scale/compare stage, and the pipeline stalls only
// when the output register is full and not taken. Write the configuration registers
// only while no sample is in flight.
module averaged_adc_thermostat
  import athm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  athm_in_if.sink               in_chan,
  athm_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg_r;
  logic             s0_v_r;
  logic [SMP_W-1:0] s0_smp_r;
  logic             s1_v_r;
  logic             out_v_r;
  logic             out_ok;
  logic             mv1;
  logic             mv0;
  logic             s1_free;
  logic             in_acc;
  prod_t            prod;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pot_gain   <= RST_POT_GAIN;
      cfg_r.pot_shift  <= RST_POT_SHIFT;
      cfg_r.pot_offset <= RST_POT_OFFSET;
      cfg_r.temp_zero  <= RST_TEMP_ZERO;
      cfg_r.temp_gain  <= RST_TEMP_GAIN;
      cfg_r.temp_shift <= RST_TEMP_SHIFT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POT_GAIN:   cfg_r.pot_gain   <= cfg_data;
        CFG_POT_SHIFT:  cfg_r.pot_shift  <= cfg_data[SHIFT_W-1:0];
        CFG_POT_OFFSET: cfg_r.pot_offset <= $signed(cfg_data);
        CFG_TEMP_ZERO:  cfg_r.temp_zero  <= cfg_data[SMP_W-1:0];
        CFG_TEMP_GAIN:  cfg_r.temp_gain  <= cfg_data;
        CFG_TEMP_SHIFT: cfg_r.temp_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake: each stage moves when the one after it has room
  assign out_ok        = ~out_v_r | out_chan.ready;
  assign mv1           = s1_v_r & out_ok;
  assign s1_free       = ~s1_v_r | mv1;
  assign mv0           = s0_v_r & s1_free;
  assign in_chan.ready = ~s0_v_r | mv0;
  assign in_acc        = in_chan.valid & in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s0_v_r <= in_chan.valid;
      end
      if (s1_free) begin
        s1_v_r <= mv0;
      end
      if (out_ok) begin
        out_v_r <= mv1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_smp_r <= in_chan.sample;
    end
  end

  athm_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (mv0),
    .sample (s0_smp_r),
    .cfg    (cfg_r),
    .prod_r (prod)
  );

  athm_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (mv1),
    .prod  (prod),
    .cfg   (cfg_r),
    .res_r (res)
  );

  assign out_chan.valid        = out_v_r;
  assign out_chan.next_channel = res.next_ch;
  assign out_chan.batch_done   = res.done;
  assign out_chan.setpoint     = res.setpoint;
  assign out_chan.actual_temp  = res.actual_temp;
  assign out_chan.drive_on     = res.drive_on;

endmodule

>>> rtl/athm_accum.sv
module athm_accum
  import athm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [SMP_W-1:0] sample,
  input  cfg_t             cfg,
  output prod_t            prod_r
);

  logic                  chan_r;
  logic [SUM_W-1:0]      pot_sum_r;
  logic [SUM_W-1:0]      temp_sum_r;
  logic [AVG_LOG2-1:0]   cnt_r;
  logic [SUM_W-1:0]      tsum_full;
  logic                  done_w;
  logic [SMP_W-1:0]      pavg;
  logic [SMP_W-1:0]      tavg;
  logic signed [SMP_W:0] tdiff;
  prod_t                 prod_nxt;

  assign tsum_full = temp_sum_r + SUM_W'(sample);
  assign done_w    = chan_r & (&cnt_r);
  assign pavg      = pot_sum_r[SUM_W-1 -: SMP_W];
  assign tavg      = tsum_full[SUM_W-1 -: SMP_W];
  assign tdiff     = $signed({1'b0, tavg}) - $signed({1'b0, cfg.temp_zero});

  always_comb begin
    prod_nxt.next_ch = ~chan_r;
    prod_nxt.done    = done_w;
    prod_nxt.pprod   = PPROD_W'(pavg) * PPROD_W'(cfg.pot_gain);
    prod_nxt.tprod   = TPROD_W'(tdiff) * TPROD_W'($signed({1'b0, cfg.temp_gain}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r     <= 1'b0;
      pot_sum_r  <= '0;
      temp_sum_r <= '0;
      cnt_r      <= '0;
    end else if (adv) begin
      chan_r <= ~chan_r;
      if (!chan_r) begin
        pot_sum_r <= pot_sum_r + SUM_W'(sample);
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (done_w) begin
          pot_sum_r  <= '0;
          temp_sum_r <= '0;
        end else begin
          temp_sum_r <= tsum_full;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

>>> rtl/athm_scale.sv
module athm_scale
  import athm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  prod_t prod,
  input  cfg_t  cfg,
  output res_t  res_r
);

  logic [PPROD_W-1:0]        psh;
  logic signed [TPROD_W-1:0] sp;
  logic signed [TPROD_W-1:0] tp;
  logic signed [RES_W-1:0]   sp_sat;
  logic signed [RES_W-1:0]   tp_sat;

  assign psh    = prod.pprod >> cfg.pot_shift;
  assign sp     = $signed(TPROD_W'(psh)) + TPROD_W'(cfg.pot_offset);
  assign tp     = prod.tprod >>> cfg.temp_shift;
  assign sp_sat = sat16(sp);
  assign tp_sat = sat16(tp);

  // held values live in the result register itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (adv) begin
      res_r.next_ch <= prod.next_ch;
      res_r.done    <= prod.done;
      if (prod.done) begin
        res_r.setpoint    <= sp_sat;
        res_r.actual_temp <= tp_sat;
        res_r.drive_on    <= (tp_sat >= sp_sat);
      end
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import athm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PAIR_SAMPLES = 2 << AVG_LOG2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef enum {MIX_UNIFORM, MIX_POT_HIGH, MIX_POT_LOW, MIX_EDGES} mix_e;

  localparam logic [SMP_W-1:0] DIRECTED [20] = '{
    12'h000, 12'hfff, 12'hfff, 12'h000, 12'haaa, 12'h555, 12'h001, 12'h800,
    12'h7ff, 12'hffe, 12'h000, 12'h000, 12'hfff, 12'hfff, 12'h555, 12'haaa,
    12'h800, 12'h001, 12'hffe, 12'h7ff
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic drv_valid = 1'b0;
  logic [SMP_W-1:0] drv_sample = '0;
  logic rcv_ready = 1'b0;

  athm_in_if in_chan ();
  athm_out_if out_chan ();

  assign in_chan.valid = drv_valid;
  assign in_chan.sample = drv_sample;
  assign out_chan.ready = rcv_ready;

  averaged_adc_thermostat i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // thermostat model state
  cfg_t mdl_cfg;
  logic mdl_on_temp;
  logic [SUM_W-1:0] mdl_pot_sum;
  logic [SUM_W-1:0] mdl_temp_sum;
  logic [AVG_LOG2-1:0] mdl_pairs;
  logic signed [RES_W-1:0] mdl_setpoint;
  logic signed [RES_W-1:0] mdl_temp;
  logic mdl_drive;

  res_t expected_words [$];
  logic [SMP_W-1:0] sample_q [$];
  int words_queued = 0;
  int words_accepted = 0;
  int fails = 0;
  int cycle_count = 0;
  bit gen_on_temp = 1'b0;

  function automatic logic signed [RES_W-1:0] clamp_s16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[RES_W-1:0];
  endfunction

  task automatic predict_sample(input logic [SMP_W-1:0] s);
    res_t w;
    longint pavg;
    longint tavg;
    longint sp;
    longint tp;
    if (!mdl_on_temp) begin
      mdl_pot_sum = mdl_pot_sum + SUM_W'(s);
      mdl_on_temp = 1'b1;
      w.done = 1'b0;
    end else begin
      mdl_temp_sum = mdl_temp_sum + SUM_W'(s);
      mdl_pairs = mdl_pairs + 1'b1;
      w.done = (mdl_pairs == '0);
      if (w.done) begin
        pavg = longint'(mdl_pot_sum >> AVG_LOG2);
        tavg = longint'(mdl_temp_sum >> AVG_LOG2);
        sp = ((pavg * longint'(mdl_cfg.pot_gain)) >> mdl_cfg.pot_shift)
             + longint'($signed(mdl_cfg.pot_offset));
        // signed longint, so >>> floors negative products
        tp = ((tavg - longint'(mdl_cfg.temp_zero)) * longint'(mdl_cfg.temp_gain))
             >>> mdl_cfg.temp_shift;
        mdl_setpoint = clamp_s16(sp);
        mdl_temp = clamp_s16(tp);
        mdl_drive = (mdl_temp >= mdl_setpoint);
        mdl_pot_sum = '0;
        mdl_temp_sum = '0;
      end
      mdl_on_temp = 1'b0;
    end
    w.next_ch = mdl_on_temp;
    w.setpoint = mdl_setpoint;
    w.actual_temp = mdl_temp;
    w.drive_on = mdl_drive;
    expected_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      CFG_POT_GAIN: mdl_cfg.pot_gain = d;
      CFG_POT_SHIFT: mdl_cfg.pot_shift = d[SHIFT_W-1:0];
      CFG_POT_OFFSET: mdl_cfg.pot_offset = d;
      CFG_TEMP_ZERO: mdl_cfg.temp_zero = d[SMP_W-1:0];
      CFG_TEMP_GAIN: mdl_cfg.temp_gain = d;
      CFG_TEMP_SHIFT: mdl_cfg.temp_shift = d[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(input logic [SMP_W-1:0] s);
    sample_q.push_back(s);
    words_queued++;
    gen_on_temp = ~gen_on_temp;
  endtask

  function automatic logic [SMP_W-1:0] pick_sample(input mix_e mix, input bit for_temp);
    case (mix)
      MIX_POT_HIGH: return for_temp ? SMP_W'($urandom_range(0, 63))
                                    : SMP_W'($urandom_range(4032, 4095));
      MIX_POT_LOW: return for_temp ? SMP_W'($urandom_range(4032, 4095))
                                   : SMP_W'($urandom_range(0, 63));
      MIX_EDGES: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return SMP_W'($urandom_range(0, 15));
          default: return SMP_W'($urandom);
        endcase
      end
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic queue_samples(input int n, input mix_e mix);
    for (int i = 0; i < n; i++) begin
      push_word(pick_sample(mix, gen_on_temp));
    end
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || words_accepted != words_queued ||
           expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_random_cfg(input logic [SMP_W-1:0] zero_floor);
    write_reg(CFG_POT_GAIN, CFG_DATA_W'($urandom));
    write_reg(CFG_POT_SHIFT, CFG_DATA_W'($urandom));
    write_reg(CFG_POT_OFFSET, CFG_DATA_W'($urandom));
    write_reg(CFG_TEMP_ZERO, CFG_DATA_W'($urandom_range(zero_floor, 4095)));
    write_reg(CFG_TEMP_GAIN, CFG_DATA_W'($urandom));
    write_reg(CFG_TEMP_SHIFT, CFG_DATA_W'($urandom));
    end_writes();
  endtask

  // sender: bursts of random length, random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (drv_valid && in_chan.ready) begin
        predict_sample(drv_sample);
        words_accepted++;
      end
      if (!drv_valid || in_chan.ready) begin
        if (gap_left > 0 || sample_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          drv_valid <= 1'b0;
        end else begin
          drv_valid <= 1'b1;
          drv_sample <= sample_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: stall rate is redrawn at random, zero rate included
  int stall_left = 0;
  int stall_pct = 0;
  res_t exp_w;

  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && rcv_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_chan.next_channel !== exp_w.next_ch) begin
            $error("next_channel: expected %0d, got %0d", exp_w.next_ch, out_chan.next_channel);
            fails++;
          end
          if (out_chan.batch_done !== exp_w.done) begin
            $error("batch_done: expected %0d, got %0d", exp_w.done, out_chan.batch_done);
            fails++;
          end
          if (out_chan.setpoint !== exp_w.setpoint) begin
            $error("setpoint: expected %0d, got %0d", exp_w.setpoint, out_chan.setpoint);
            fails++;
          end
          if (out_chan.actual_temp !== exp_w.actual_temp) begin
            $error("actual_temp: expected %0d, got %0d", exp_w.actual_temp,
                   out_chan.actual_temp);
            fails++;
          end
          if (out_chan.drive_on !== exp_w.drive_on) begin
            $error("drive_on: expected %0d, got %0d", exp_w.drive_on, out_chan.drive_on);
            fails++;
          end
        end
      end
      if (cycle_count % 300 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 40;
          default: stall_pct = 70;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mdl_cfg.pot_gain = RST_POT_GAIN;
    mdl_cfg.pot_shift = RST_POT_SHIFT;
    mdl_cfg.pot_offset = RST_POT_OFFSET;
    mdl_cfg.temp_zero = RST_TEMP_ZERO;
    mdl_cfg.temp_gain = RST_TEMP_GAIN;
    mdl_cfg.temp_shift = RST_TEMP_SHIFT;
    mdl_on_temp = 1'b0;
    mdl_pot_sum = '0;
    mdl_temp_sum = '0;
    mdl_pairs = '0;
    mdl_setpoint = '0;
    mdl_temp = '0;
    mdl_drive = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // batch 0: directed extremes at reset settings
    foreach (DIRECTED[i]) push_word(DIRECTED[i]);
    wait_drained();
    // spare indexes are ignored; upper bits of narrow registers are masked off
    write_reg(IDX_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(IDX_SPARE_HI, CFG_DATA_W'($urandom));
    write_reg(CFG_POT_SHIFT, 16'hffec);
    write_reg(CFG_TEMP_ZERO, 16'hf9ab);
    write_reg(CFG_TEMP_SHIFT, 16'hfff0);
    end_writes();
    queue_samples(PAIR_SAMPLES - $size(DIRECTED), MIX_UNIFORM);
    wait_drained();

    // batch 1: random settings, then the top extremes mid-batch (both saturate high)
    write_random_cfg('0);
    queue_samples(PAIR_SAMPLES / 2, MIX_UNIFORM);
    wait_drained();
    write_reg(CFG_POT_GAIN, 16'hffff);
    write_reg(CFG_POT_SHIFT, 16'd0);
    write_reg(CFG_POT_OFFSET, 16'h7fff);
    write_reg(CFG_TEMP_ZERO, 16'd0);
    write_reg(CFG_TEMP_GAIN, 16'hffff);
    write_reg(CFG_TEMP_SHIFT, 16'd0);
    end_writes();
    queue_samples(PAIR_SAMPLES / 2, MIX_UNIFORM);
    wait_drained();

    // batch 2: bottom extremes, temperature saturates low
    write_reg(CFG_POT_SHIFT, 16'd31);
    write_reg(CFG_POT_OFFSET, 16'h8000);
    write_reg(CFG_TEMP_ZERO, 16'h0fff);
    end_writes();
    queue_samples(PAIR_SAMPLES, MIX_POT_HIGH);
    wait_drained();

    // batch 3: random settings, high zero point so the product can go negative
    write_random_cfg(12'd2048);
    queue_samples(PAIR_SAMPLES / 2, MIX_EDGES);
    queue_samples(PAIR_SAMPLES / 2, MIX_POT_LOW);
    wait_drained();

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
